/* src/mtrsp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mtrsp_pkg
// Types and constants shared by the track run sample parser modules.
// ----------------------------------------------------------------------------
package mtrsp_pkg;

    // Run header flag bits
    localparam logic [23:0] F_OFFSET = 24'h000001;
    localparam logic [23:0] F_FIRST  = 24'h000004;
    localparam logic [23:0] F_DUR    = 24'h000100;
    localparam logic [23:0] F_SIZE   = 24'h000200;
    localparam logic [23:0] F_FLAGS  = 24'h000400;
    localparam logic [23:0] F_CTO    = 24'h000800;

    // Box type of a track run, 'trun'
    localparam logic [31:0] TRUN_TYPE = 32'h7472756E;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_FRAG_DUR    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRACK_DUR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAG_SIZE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRACK_SIZE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FRAG_FLAGS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TRACK_FLAGS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_TIME   = 3'd6;

    localparam int unsigned OUT_DATA_W = 224;

    typedef struct packed {
        logic [31:0] frag_dur;
        logic [31:0] track_dur;
        logic [31:0] frag_size;
        logic [31:0] track_size;
        logic [31:0] frag_flags;
        logic [31:0] track_flags;
    } t_cfg;

    typedef struct packed {
        logic        last;
        logic [31:0] cto;
        logic [31:0] flags;
        logic [31:0] size;
        logic [31:0] offset;
        logic [31:0] dur;
        logic [63:0] time_val;
    } t_sample;

endpackage
`default_nettype wire

/* src/mtrsp_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mtrsp_core
// Box and run header parser state, sample field assembly and the running
// decode time and byte position. One item is processed per i_go cycle.
// ----------------------------------------------------------------------------
module mtrsp_core
    import mtrsp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_go,
    input  wire logic        i_mode,
    input  wire logic [7:0]  i_byte,
    input  wire t_cfg        i_cfg,
    input  wire logic        i_time_load,
    input  wire logic [63:0] i_time_value,
    output logic             o_emit,
    output t_sample          o_sample
);

    localparam logic [3:0] PH_BOX_SIZE  = 4'd0;
    localparam logic [3:0] PH_BOX_TYPE  = 4'd1;
    localparam logic [3:0] PH_SKIP      = 4'd2;
    localparam logic [3:0] PH_RUN_FLAGS = 4'd3;
    localparam logic [3:0] PH_COUNT     = 4'd4;
    localparam logic [3:0] PH_OFFSET    = 4'd5;
    localparam logic [3:0] PH_FIRST     = 4'd6;
    localparam logic [3:0] PH_DUR       = 4'd7;
    localparam logic [3:0] PH_SZ        = 4'd8;
    localparam logic [3:0] PH_FLG       = 4'd9;
    localparam logic [3:0] PH_CTO       = 4'd10;
    localparam logic [3:0] PH_ADVANCE   = 4'd11;
    localparam logic [3:0] PH_NONE      = 4'd15;

    // First per-sample field after phase 'from' that the run carries.
    function automatic logic [3:0] f_next_field(input logic [3:0] from,
                                                input logic [23:0] flags);
        logic [3:0] p;
        p = PH_NONE;
        if (from < PH_CTO && (flags & F_CTO) != 24'd0)   p = PH_CTO;
        if (from < PH_FLG && (flags & F_FLAGS) != 24'd0) p = PH_FLG;
        if (from < PH_SZ && (flags & F_SIZE) != 24'd0)   p = PH_SZ;
        if (from < PH_DUR && (flags & F_DUR) != 24'd0)   p = PH_DUR;
        return p;
    endfunction

    // Phase entered at the start of a sample, given the samples still left.
    function automatic logic [3:0] f_begin_phase(input logic [31:0] left,
                                                 input logic [3:0] field);
        logic [3:0] p;
        if (left == 32'd0) begin
            p = PH_BOX_SIZE;
        end else if (field == PH_NONE) begin
            p = PH_ADVANCE;
        end else begin
            p = field;
        end
        return p;
    endfunction

    logic [3:0]  r_phase, n_phase;
    logic [1:0]  r_bif, n_bif;
    logic [31:0] r_word, n_word;
    logic [31:0] r_skip, n_skip;
    logic [23:0] r_flags, n_flags;
    logic [31:0] r_left, n_left;
    logic [31:0] r_first_word, n_first_word;
    logic        r_first_pend, n_first_pend;
    logic [63:0] r_time, n_time;
    logic [31:0] r_pos, n_pos;
    logic [31:0] r_dur, n_dur;
    logic [31:0] r_size, n_size;
    logic [31:0] r_sflags, n_sflags;

    logic [3:0]  eff_phase;
    logic [1:0]  eff_bif;
    logic [31:0] word_new;
    logic        done;
    logic        emit;
    logic [31:0] cto;
    logic [3:0]  first_field;
    logic [31:0] skip_less;
    logic [3:0]  nf;
    logic [31:0] sel_dur, sel_size, sel_flags;

    assign word_new    = {r_word[23:0], i_byte};
    assign first_field = f_next_field(PH_FIRST, r_flags);
    assign skip_less   = (r_skip < 32'd8) ? 32'd0 : r_skip - 32'd8;

    always_comb begin
        n_phase      = r_phase;
        n_bif        = r_bif;
        n_word       = r_word;
        n_skip       = r_skip;
        n_flags      = r_flags;
        n_left       = r_left;
        n_first_word = r_first_word;
        n_first_pend = r_first_pend;
        n_time       = r_time;
        n_pos        = r_pos;
        n_dur        = r_dur;
        n_size       = r_size;
        n_sflags     = r_sflags;
        emit         = 1'b0;
        cto          = 32'd0;
        nf           = PH_NONE;
        eff_phase    = r_phase;
        eff_bif      = r_bif;
        done         = 1'b0;

        if (i_mode) begin
            if (r_phase == PH_ADVANCE && r_left != 32'd0) begin
                emit = 1'b1;
            end
        end else begin
            // A stream byte ends a field-less run and starts the next box.
            if (r_phase == PH_ADVANCE) begin
                eff_phase    = PH_BOX_SIZE;
                eff_bif      = 2'd0;
                n_left       = 32'd0;
                n_first_pend = 1'b0;
            end
            done = (eff_bif == 2'd3);
            if (eff_phase != PH_SKIP && eff_phase <= PH_CTO) begin
                n_word = word_new;
                n_bif  = eff_bif + 2'd1;
            end
            case (eff_phase)
                PH_BOX_SIZE: begin
                    if (done) begin
                        n_skip  = word_new;
                        n_phase = PH_BOX_TYPE;
                    end else begin
                        n_phase = PH_BOX_SIZE;
                    end
                end
                PH_BOX_TYPE: begin
                    if (done) begin
                        if (word_new == TRUN_TYPE) begin
                            n_phase = PH_RUN_FLAGS;
                        end else begin
                            n_skip  = skip_less;
                            n_phase = (skip_less == 32'd0) ? PH_BOX_SIZE : PH_SKIP;
                        end
                    end
                end
                PH_SKIP: begin
                    n_skip = r_skip - 32'd1;
                    if (r_skip == 32'd1) begin
                        n_phase = PH_BOX_SIZE;
                    end
                end
                PH_RUN_FLAGS: begin
                    if (done) begin
                        n_flags = word_new[23:0];
                        n_phase = PH_COUNT;
                    end
                end
                PH_COUNT: begin
                    if (done) begin
                        n_left       = word_new;
                        n_first_pend = 1'b0;
                        if ((r_flags & F_OFFSET) != 24'd0) begin
                            n_phase = PH_OFFSET;
                        end else begin
                            n_pos   = 32'd0;
                            n_phase = ((r_flags & F_FIRST) != 24'd0) ? PH_FIRST
                                      : f_begin_phase(word_new, first_field);
                        end
                    end
                end
                PH_OFFSET: begin
                    if (done) begin
                        n_pos   = word_new;
                        n_phase = ((r_flags & F_FIRST) != 24'd0) ? PH_FIRST
                                  : f_begin_phase(r_left, first_field);
                    end
                end
                PH_FIRST: begin
                    if (done) begin
                        n_first_word = word_new;
                        n_first_pend = 1'b1;
                        n_phase      = f_begin_phase(r_left, first_field);
                    end
                end
                PH_DUR, PH_SZ, PH_FLG: begin
                    if (done) begin
                        if (eff_phase == PH_DUR) begin
                            n_dur = word_new;
                        end else if (eff_phase == PH_SZ) begin
                            n_size = word_new;
                        end else begin
                            n_sflags = word_new;
                        end
                        nf = f_next_field(eff_phase, r_flags);
                        if (nf == PH_NONE) begin
                            emit = 1'b1;
                        end else begin
                            n_phase = nf;
                        end
                    end
                end
                PH_CTO: begin
                    if (done) begin
                        emit = 1'b1;
                        cto  = word_new;
                    end
                end
                default: begin
                    n_phase = PH_BOX_SIZE;
                    n_bif   = 2'd0;
                end
            endcase
        end

        // Field values come from this item when it completed them.
        if ((r_flags & F_DUR) != 24'd0) begin
            sel_dur = n_dur;
        end else begin
            sel_dur = (i_cfg.frag_dur != 32'd0) ? i_cfg.frag_dur : i_cfg.track_dur;
        end
        if ((r_flags & F_SIZE) != 24'd0) begin
            sel_size = n_size;
        end else begin
            sel_size = (i_cfg.frag_size != 32'd0) ? i_cfg.frag_size : i_cfg.track_size;
        end
        if ((r_flags & F_FLAGS) != 24'd0) begin
            sel_flags = n_sflags;
        end else if (r_first_pend) begin
            sel_flags = r_first_word;
        end else begin
            sel_flags = (i_cfg.frag_flags != 32'd0) ? i_cfg.frag_flags : i_cfg.track_flags;
        end

        if (emit) begin
            n_time       = r_time + {32'd0, sel_dur};
            n_pos        = r_pos + sel_size;
            n_left       = r_left - 32'd1;
            n_first_pend = 1'b0;
            n_phase      = f_begin_phase(r_left - 32'd1, first_field);
        end
    end

    always_comb begin
        o_emit            = i_go && emit;
        o_sample.time_val = r_time;
        o_sample.dur      = sel_dur;
        o_sample.offset   = r_pos;
        o_sample.size     = sel_size;
        o_sample.flags    = sel_flags;
        o_sample.cto      = ((r_flags & F_CTO) != 24'd0) ? cto : 32'd0;
        o_sample.last     = (r_left == 32'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_BOX_SIZE;
            r_bif        <= 2'd0;
            r_word       <= 32'd0;
            r_skip       <= 32'd0;
            r_flags      <= 24'd0;
            r_left       <= 32'd0;
            r_first_word <= 32'd0;
            r_first_pend <= 1'b0;
            r_time       <= 64'd0;
            r_pos        <= 32'd0;
            r_dur        <= 32'd0;
            r_size       <= 32'd0;
            r_sflags     <= 32'd0;
        end else if (i_time_load) begin
            r_time <= i_time_value;
        end else if (i_go) begin
            r_phase      <= n_phase;
            r_bif        <= n_bif;
            r_word       <= n_word;
            r_skip       <= n_skip;
            r_flags      <= n_flags;
            r_left       <= n_left;
            r_first_word <= n_first_word;
            r_first_pend <= n_first_pend;
            r_time       <= n_time;
            r_pos        <= n_pos;
            r_dur        <= n_dur;
            r_size       <= n_size;
            r_sflags     <= n_sflags;
        end
    end

endmodule
`default_nettype wire

/* src/mp4_track_run_sample_parser_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mp4_track_run_sample_parser_top
// Parses track fragment box bytes into per-sample timing and position items.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                    Carries
//  s_axis    in         s_axis_tvalid/s_axis_tready  stream byte or advance
//  m_axis    out        m_axis_tvalid/m_axis_tready  one sample per item
//  cfg       in         i_cfg_valid/o_cfg_ready      register index and value
//
//  One input item per cycle sustained while results are taken. An accepted
//  item waits in the input register until the parser can take it; the parser
//  then updates its state and, when a sample completes, loads the result register.
//  A result that is not taken holds the input register; s_axis_tready drops
//  only while the input register is full and cannot move on.
//  Reset is synchronous; no clearing pass.
// ----------------------------------------------------------------------------
module mp4_track_run_sample_parser_top
    import mtrsp_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [7:0]            s_axis_tdata,   // [7:0] data_byte
    input  wire logic                  s_axis_tuser,   // [0] mode
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [63:0] sample_time, [95:64] sample_duration, [127:96] sample_offset,
    // [159:128] sample_size, [191:160] sample_flags, [223:192] composition_offset
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    output logic                       m_axis_tlast,   // last_in_run
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [63:0]           i_cfg_data
);

    t_cfg        r_cfg;
    logic        r_in_valid;
    logic        r_in_mode;
    logic [7:0]  r_in_byte;
    logic        r_out_valid;
    t_sample     r_out;
    logic        proc_go;
    logic        cfg_wr;
    logic        time_load;
    logic        core_emit;
    t_sample     core_sample;

    assign proc_go       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || proc_go;
    assign o_cfg_ready   = 1'b1;
    assign cfg_wr        = i_cfg_valid && o_cfg_ready;
    assign time_load     = cfg_wr && (i_cfg_index == REG_BASE_TIME);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                REG_FRAG_DUR:    r_cfg.frag_dur    <= i_cfg_data[31:0];
                REG_TRACK_DUR:   r_cfg.track_dur   <= i_cfg_data[31:0];
                REG_FRAG_SIZE:   r_cfg.frag_size   <= i_cfg_data[31:0];
                REG_TRACK_SIZE:  r_cfg.track_size  <= i_cfg_data[31:0];
                REG_FRAG_FLAGS:  r_cfg.frag_flags  <= i_cfg_data[31:0];
                REG_TRACK_FLAGS: r_cfg.track_flags <= i_cfg_data[31:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (proc_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_mode <= s_axis_tuser;
            r_in_byte <= s_axis_tdata;
        end
    end

    mtrsp_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_go         (proc_go),
        .i_mode       (r_in_mode),
        .i_byte       (r_in_byte),
        .i_cfg        (r_cfg),
        .i_time_load  (time_load),
        .i_time_value (i_cfg_data),
        .o_emit       (core_emit),
        .o_sample     (core_sample)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (core_emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_emit) begin
            r_out <= core_sample;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.cto, r_out.flags, r_out.size, r_out.offset,
                            r_out.dur, r_out.time_val};
    assign m_axis_tlast  = r_out.last;

    // A waiting result must never be overwritten by a new one.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |-> !core_emit)
        else $error("result register overwritten while stalled");

    // Input is refused only while the input register holds an item.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> s_axis_tready)
        else $error("input refused with empty input register");

    // A taken result with nothing new behind it leaves the output empty.
    a_out_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !core_emit) |=> !m_axis_tvalid)
        else $error("result repeated after it was taken");

    // Processing only happens on a held input item.
    a_go_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc_go |-> r_in_valid)
        else $error("parser advanced without an item");

endmodule
`default_nettype wire
